// ===== src/chkc_pkg.sv =====
// chkc_pkg: shared constants, field layout and codes of the complex history kernel convolver
// no dependencies; imported by complex_history_kernel_convolver
package chkc_pkg;

    // default sizes handed to the top level parameters
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int WEIGHT_BITS_DEF   = 32;
    localparam int SAMPLE_BITS_DEF   = 24;

    // fixed point and output format
    localparam int QSHIFT      = 30;
    localparam int OUT_BITS    = 48;
    localparam int FACTOR_BITS = 32;

    // input transfer field widths
    localparam int INDEX_BITS     = 10;
    localparam int IN_WEIGHT_BITS = 32;
    localparam int IN_SAMPLE_BITS = 24;

    // stream bus widths
    localparam int S_TDATA_BITS = 128;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 96;

    // input tdata field offsets
    localparam int IDX_LSB  = 0;
    localparam int WVAL_LSB = IDX_LSB + INDEX_BITS;
    localparam int SRE_LSB  = WVAL_LSB + IN_WEIGHT_BITS;
    localparam int SIM_LSB  = SRE_LSB + IN_SAMPLE_BITS;
    localparam int FAC_LSB  = SIM_LSB + IN_SAMPLE_BITS;

    typedef enum logic [S_TUSER_BITS-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_CONV  = 2'd2,
        KIND_SCALE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CONV   = 4'b0010,
        ST_SCALE  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

endpackage

// ===== src/complex_history_kernel_convolver.sv =====
// complex_history_kernel_convolver: weight table and complex sample ring in two memories,
// one multiply-accumulate path for convolve and weight scaling; depends on chkc_pkg
//
//   channel   direction  fields
//   s_axis    in         tuser: kind; tdata: weight_index, weight_value, sample_real,
//                        sample_imag, scale_factor
//   m_axis    out        tdata: real_sum, imag_sum (one transfer per convolve)
//
// convolve visits the filled_count newest samples and scale all HISTORY_DEPTH weights,
// each one memory entry per cycle through the single read port of each memory and the
// shared multipliers, followed by a read and a multiply stage.
// reset clears only control state; memory entries are undefined until written.
// input is taken only when idle; a finished sum waits in the output register, and a second
// convolve holds in its final cycle until that register is taken.
module complex_history_kernel_convolver
    import chkc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
)(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // weight_index[9:0], weight_value[41:10], sample_real[65:42], sample_imag[89:66],
    // scale_factor[121:90], zero fill
    input  logic [S_TDATA_BITS-1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [S_TUSER_BITS-1:0] s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // real_sum[47:0], imag_sum[95:48]
    output logic [M_TDATA_BITS-1:0] m_axis_tdata
);

    localparam int AW    = $clog2(HISTORY_DEPTH);
    localparam int CW    = AW + 1;
    localparam int PW    = WEIGHT_BITS + FACTOR_BITS;
    localparam int ACC_W = WEIGHT_BITS + SAMPLE_BITS + AW + 1;
    localparam int SUM_W = ACC_W + OUT_BITS + 1;
    localparam int LW    = WEIGHT_BITS + IN_WEIGHT_BITS;
    localparam int LS    = SAMPLE_BITS + IN_SAMPLE_BITS;

    localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [OUT_BITS-1:0]    O_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0]    O_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

    // input fields
    kind_t                             in_kind;
    logic        [INDEX_BITS-1:0]      in_index;
    logic signed [IN_WEIGHT_BITS-1:0]  in_weight;
    logic signed [IN_SAMPLE_BITS-1:0]  in_re;
    logic signed [IN_SAMPLE_BITS-1:0]  in_im;
    logic signed [FACTOR_BITS-1:0]     in_factor;

    assign in_kind   = kind_t'(s_axis_tuser);
    assign in_index  = s_axis_tdata[IDX_LSB +: INDEX_BITS];
    assign in_weight = s_axis_tdata[WVAL_LSB +: IN_WEIGHT_BITS];
    assign in_re     = s_axis_tdata[SRE_LSB +: IN_SAMPLE_BITS];
    assign in_im     = s_axis_tdata[SIM_LSB +: IN_SAMPLE_BITS];
    assign in_factor = s_axis_tdata[FAC_LSB +: FACTOR_BITS];

    // control registers
    state_t          state_reg,   state_next;
    logic [CW-1:0]   cnt_reg,     cnt_next;
    logic [CW-1:0]   limit_reg,   limit_next;
    logic [CW-1:0]   filled_reg,  filled_next;
    logic [AW-1:0]   newest_reg,  newest_next;
    logic            rd_vld_reg,  rd_vld_next;
    logic            mul_vld_reg, mul_vld_next;
    logic            m_vld_reg,   m_vld_next;

    // payload registers
    logic        [AW-1:0]          hp_reg,      hp_next;
    logic        [AW-1:0]          addr1_reg,   addr1_next;
    logic        [AW-1:0]          addr2_reg,   addr2_next;
    logic signed [FACTOR_BITS-1:0] factor_reg,  factor_next;
    logic signed [PW-1:0]          prod_re_reg, prod_re_next;
    logic signed [PW-1:0]          prod_im_reg, prod_im_next;
    logic signed [ACC_W-1:0]       acc_re_reg,  acc_re_next;
    logic signed [ACC_W-1:0]       acc_im_reg,  acc_im_next;
    logic        [OUT_BITS-1:0]    out_re_reg,  out_re_next;
    logic        [OUT_BITS-1:0]    out_im_reg,  out_im_next;

    // memories
    logic [WEIGHT_BITS-1:0]   w_mem [HISTORY_DEPTH];
    logic [2*SAMPLE_BITS-1:0] h_mem [HISTORY_DEPTH];
    logic [WEIGHT_BITS-1:0]   w_rdata_reg;
    logic [2*SAMPLE_BITS-1:0] h_rdata_reg;
    logic                     w_we;
    logic [AW-1:0]            w_waddr;
    logic [WEIGHT_BITS-1:0]   w_wdata;
    logic                     h_we;
    logic [AW-1:0]            h_waddr;
    logic [2*SAMPLE_BITS-1:0] h_wdata;

    logic                          accept;
    logic                          issue;
    logic                          done;
    logic                          index_ok;
    logic [AW-1:0]                 pos_dec;
    logic signed [LW-1:0]          ld_ext;
    logic signed [WEIGHT_BITS-1:0] ld_sat;
    logic signed [LS-1:0]          re_ext;
    logic signed [LS-1:0]          im_ext;
    logic signed [SAMPLE_BITS-1:0] re_sat;
    logic signed [SAMPLE_BITS-1:0] im_sat;
    logic signed [WEIGHT_BITS-1:0] mul_a;
    logic signed [FACTOR_BITS-1:0] mul_b_re;
    logic signed [FACTOR_BITS-1:0] mul_b_im;
    logic signed [PW-1:0]          sc_shift;
    logic signed [WEIGHT_BITS-1:0] sc_sat;
    logic                          out_load;

    // floor shift by the q format and saturate to the output width
    function automatic logic [OUT_BITS-1:0] finish_sum(input logic signed [ACC_W-1:0] a);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(a) >>> QSHIFT;
        if (t > SUM_W'(O_MAX))
            return O_MAX;
        else if (t < SUM_W'(O_MIN))
            return O_MIN;
        else
            return t[OUT_BITS-1:0];
    endfunction

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = {out_im_reg, out_re_reg};

    // saturation of loaded weights and pushed samples
    assign ld_ext = LW'(in_weight);
    assign ld_sat = (ld_ext > LW'(W_MAX)) ? W_MAX :
                    (ld_ext < LW'(W_MIN)) ? W_MIN : ld_ext[WEIGHT_BITS-1:0];
    assign re_ext = LS'(in_re);
    assign re_sat = (re_ext > LS'(S_MAX)) ? S_MAX :
                    (re_ext < LS'(S_MIN)) ? S_MIN : re_ext[SAMPLE_BITS-1:0];
    assign im_ext = LS'(in_im);
    assign im_sat = (im_ext > LS'(S_MAX)) ? S_MAX :
                    (im_ext < LS'(S_MIN)) ? S_MIN : im_ext[SAMPLE_BITS-1:0];

    assign index_ok = (32'(in_index) < 32'(HISTORY_DEPTH));
    assign pos_dec  = (newest_reg == '0) ? AW'(HISTORY_DEPTH - 1) : newest_reg - 1'b1;

    // read issue and pipeline drain
    assign issue = ((state_reg == ST_CONV) || (state_reg == ST_SCALE)) && (cnt_reg != limit_reg);
    assign done  = (cnt_reg == limit_reg) && !rd_vld_reg && !mul_vld_reg;

    // shared multipliers: weight by factor when scaling, weight by sample when convolving
    assign mul_a    = w_rdata_reg;
    assign mul_b_re = (state_reg == ST_SCALE) ? factor_reg
                    : FACTOR_BITS'($signed(h_rdata_reg[SAMPLE_BITS-1:0]));
    assign mul_b_im = FACTOR_BITS'($signed(h_rdata_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]));

    assign sc_shift = prod_re_reg >>> QSHIFT;
    assign sc_sat   = (sc_shift > PW'(W_MAX)) ? W_MAX :
                      (sc_shift < PW'(W_MIN)) ? W_MIN : sc_shift[WEIGHT_BITS-1:0];

    // memory write ports
    assign w_we    = (accept && (in_kind == KIND_LOAD) && index_ok)
                   || ((state_reg == ST_SCALE) && mul_vld_reg);
    assign w_waddr = (state_reg == ST_SCALE) ? addr2_reg : AW'(in_index);
    assign w_wdata = (state_reg == ST_SCALE) ? sc_sat : ld_sat;
    assign h_we    = accept && (in_kind == KIND_PUSH);
    assign h_waddr = pos_dec;
    assign h_wdata = {im_sat, re_sat};

    assign out_load = (state_reg == ST_FINISH) && (!m_vld_reg || m_axis_tready);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        limit_next   = limit_reg;
        filled_next  = filled_reg;
        newest_next  = newest_reg;
        rd_vld_next  = issue;
        mul_vld_next = rd_vld_reg;
        m_vld_next   = m_vld_reg;
        hp_next      = hp_reg;
        addr1_next   = addr1_reg;
        addr2_next   = addr1_reg;
        factor_next  = factor_reg;
        prod_re_next = mul_a * mul_b_re;
        prod_im_next = mul_a * mul_b_im;
        acc_re_next  = acc_re_reg;
        acc_im_next  = acc_im_reg;
        out_re_next  = out_re_reg;
        out_im_next  = out_im_reg;

        if (m_vld_reg && m_axis_tready)
            m_vld_next = 1'b0;

        if (issue)
        begin
            cnt_next   = cnt_reg + 1'b1;
            addr1_next = cnt_reg[AW-1:0];
            hp_next    = (hp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : hp_reg + 1'b1;
        end

        if ((state_reg == ST_CONV) && mul_vld_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(prod_re_reg);
            acc_im_next = acc_im_reg + ACC_W'(prod_im_reg);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_kind)
                        KIND_PUSH:
                        begin
                            newest_next = pos_dec;
                            if (filled_reg != CW'(HISTORY_DEPTH))
                                filled_next = filled_reg + 1'b1;
                        end
                        KIND_CONV:
                        begin
                            state_next  = ST_CONV;
                            cnt_next    = '0;
                            limit_next  = filled_reg;
                            hp_next     = newest_reg;
                            acc_re_next = '0;
                            acc_im_next = '0;
                        end
                        KIND_SCALE:
                        begin
                            state_next  = ST_SCALE;
                            cnt_next    = '0;
                            limit_next  = CW'(HISTORY_DEPTH);
                            factor_next = in_factor;
                        end
                        default:
                        begin
                            // weight load is written straight into memory
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_CONV:
            begin
                if (done)
                    state_next = ST_FINISH;
            end
            ST_SCALE:
            begin
                if (done)
                    state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    out_re_next = finish_sum(acc_re_reg);
                    out_im_next = finish_sum(acc_im_reg);
                    m_vld_next  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            limit_reg   <= '0;
            filled_reg  <= '0;
            newest_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            m_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            limit_reg   <= limit_next;
            filled_reg  <= filled_next;
            newest_reg  <= newest_next;
            rd_vld_reg  <= rd_vld_next;
            mul_vld_reg <= mul_vld_next;
            m_vld_reg   <= m_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hp_reg      <= hp_next;
        addr1_reg   <= addr1_next;
        addr2_reg   <= addr2_next;
        factor_reg  <= factor_next;
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        out_re_reg  <= out_re_next;
        out_im_reg  <= out_im_next;
    end

    // weight table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        w_rdata_reg <= w_mem[cnt_reg[AW-1:0]];
    end

    // sample ring, imaginary part in the upper half
    always_ff @(posedge clk)
    begin
        if (h_we)
            h_mem[h_waddr] <= h_wdata;
        h_rdata_reg <= h_mem[hp_reg];
    end

endmodule
